FILE: hw/rtl/gspl_pkg.sv
package gspl_pkg;

  // Fraction bits of the log-domain fixed-point values.
  localparam int unsigned Q_FRAC = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_RES   = 3'd0,
    CFG_BASE_RES   = 3'd1,
    CFG_CURVE_PPM  = 3'd2,
    CFG_CURVE_RAT  = 3'd3,
    CFG_CURVE_SLP  = 3'd4,
    CFG_ALARM_THR  = 3'd5
  } cfg_idx_e;

  // log10(2) and log2(10) in Q16.
  localparam logic [15:0] LOG10_2_Q16 = 16'd19728;
  localparam logic [17:0] LOG2_10_Q16 = 18'd217707;

endpackage

FILE: hw/rtl/gas_sensor_ppm_power_law_core.sv
// Gas concentration from one resistive divider sample, via a log-log power law.
//
// Input channel: adc_sample_i with in_valid_i; a request is taken on a rising
// edge where in_valid_i is high and in_stall_o is low. Output channel: ppm_o,
// over_alarm_o and sample_invalid_o with out_valid_o; the receiver holds a
// result by raising out_stall_i.
// The configuration port writes one register per cycle with cfg_we_i; write it
// only while no request is in flight.
// The path from an accepted request to its result is two
// log2 units of 16 squaring stages, a restoring divider of 33 stages (one
// quotient bit each) and a 2^x unit of 16 multiply stages, plus glue stages.
// Throughput is one request per cycle while no result is held at the output.
// Reset clears every valid bit and loads the default curve and resistances.
// When a waiting result is stalled the whole pipeline holds in place and
// in_stall_o rises; nothing is lost or repeated, and bubbles are not squeezed.
// A zero sample returns ppm 0 with sample_invalid_o set.
module gas_sensor_ppm_power_law_core #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned PPM_BITS    = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gspl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gspl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          adc_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [PPM_BITS-1:0]             ppm_o,
  output logic                            over_alarm_o,
  output logic                            sample_invalid_o
);
  import gspl_pkg::*;

  localparam int unsigned NW    = SAMPLE_BITS + 16;    // divider products
  localparam int unsigned TOPW  = $clog2(NW);
  localparam int unsigned L2W   = TOPW + Q_FRAC + 2;   // signed log2 ratio
  localparam int unsigned LRP   = L2W + 16;            // log10 product
  localparam int unsigned DW    = ((L2W > 24) ? L2W : 24) + 1;
  localparam int unsigned NUMW  = DW + 8;              // dividend magnitude
  localparam int unsigned TW    = NUMW + 2;            // signed log10 ppm
  localparam int unsigned TC_W  = 20;                  // clamp limit 2^20
  localparam int unsigned PRW   = TC_W + 18;
  localparam int unsigned EW    = PRW - Q_FRAC;
  localparam int unsigned CW    = (PPM_BITS > 20) ? PPM_BITS : 20;
  localparam logic [31:0] PPM_MAX  = 32'((64'd1 << PPM_BITS) - 64'd1);
  localparam logic [EW-1:0] E_SAT  = EW'(PPM_BITS * 65536);

  // Configuration registers.
  logic [15:0] load_q, base_q;
  logic [15:0] clp_q, clr_q, slope_q;
  logic [19:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= 16'd2560;
      base_q  <= 16'd2560;
      clp_q   <= 16'd589;
      clr_q   <= 16'd184;
      slope_q <= 16'hFFA9;
      thr_q   <= 20'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOAD_RES:  load_q  <= cfg_data_i[15:0];
        CFG_BASE_RES:  base_q  <= cfg_data_i[15:0];
        CFG_CURVE_PPM: clp_q   <= cfg_data_i[15:0];
        CFG_CURVE_RAT: clr_q   <= cfg_data_i[15:0];
        CFG_CURVE_SLP: slope_q <= cfg_data_i[15:0];
        CFG_ALARM_THR: thr_q   <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole unless a finished result is being held.
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 0: numerator (F - s) * Rload and denominator s * Rbase.
  logic [SAMPLE_BITS-1:0] s_neg;
  logic [NW-1:0]          n_d, d_d, n_q, d_q;
  logic                   p0_v_q, p0_inv_q;

  always_comb begin
    s_neg = SAMPLE_BITS'(0) - adc_sample_i;
    n_d   = NW'(s_neg) * NW'(load_q);
    d_d   = NW'(adc_sample_i) * NW'(base_q);
    if (n_d == '0) begin
      n_d = NW'(1);
    end
    if (d_d == '0) begin
      d_d = NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (adv) begin
      p0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q      <= n_d;
      d_q      <= d_d;
      p0_inv_q <= (adc_sample_i == '0);
    end
  end

  // Two log2 units, one per side of the ratio.
  logic              ln_v, ld_v, ln_tag, ld_tag;
  logic [TOPW-1:0]   ln_top, ld_top;
  logic [Q_FRAC-1:0] ln_frac, ld_frac;

  gspl_log2 #(.XW(NW), .TAG_W(1)) u_log_n (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p0_v_q), .x_i(n_q), .tag_i(p0_inv_q),
    .valid_o(ln_v), .top_o(ln_top), .frac_o(ln_frac), .tag_o(ln_tag)
  );

  gspl_log2 #(.XW(NW), .TAG_W(1)) u_log_d (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p0_v_q), .x_i(d_q), .tag_i(p0_inv_q),
    .valid_o(ld_v), .top_o(ld_top), .frac_o(ld_frac), .tag_o(ld_tag)
  );

  // Stage 1: log2 of the ratio.
  logic signed [L2W-1:0] l2_q;
  logic                  p1_v_q, p1_inv_q;

  // Stage 2: scaled by log10(2).
  logic signed [LRP-1:0] lrp_q;
  logic                  p2_v_q, p2_inv_q;

  // Stage 3: log10 of the ratio, truncated toward zero.
  logic signed [LRP-1:0] lr_adj;
  logic signed [L2W-1:0] lr_q;
  logic                  p3_v_q, p3_inv_q;

  assign lr_adj = lrp_q + (lrp_q[LRP-1] ? LRP'(65535) : LRP'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= ln_v & ld_v;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l2_q     <= $signed(L2W'({ln_top, ln_frac})) - $signed(L2W'({ld_top, ld_frac}));
      p1_inv_q <= ln_tag | ld_tag;
      lrp_q    <= $signed({{16{l2_q[L2W-1]}}, l2_q}) * $signed(LRP'(LOG10_2_Q16));
      p2_inv_q <= p1_inv_q;
      lr_q     <= L2W'(lr_adj >>> Q_FRAC);
      p3_inv_q <= p2_inv_q;
    end
  end

  // Dividend (lr - log10 ratio point) * 256 and slope, as magnitudes and sign.
  logic signed [DW-1:0] diff;
  logic [NUMW-1:0]      num_raw, num_mag;
  logic [15:0]          slope_eff, den_mag;
  logic                 qneg;

  always_comb begin
    diff      = DW'(lr_q) - DW'($signed({clr_q, 8'h00}));
    num_raw   = {diff, 8'h00};
    num_mag   = diff[DW-1] ? (~num_raw + NUMW'(1)) : num_raw;
    slope_eff = (slope_q == 16'h0000) ? 16'hFFFF : slope_q;
    den_mag   = slope_eff[15] ? (~slope_eff + 16'd1) : slope_eff;
    qneg      = diff[DW-1] ^ slope_eff[15];
  end

  logic            dv_v;
  logic [NUMW-1:0] dv_quot;
  logic [1:0]      dv_tag;

  gspl_div #(.NUM_W(NUMW), .DEN_W(16), .TAG_W(2)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p3_v_q), .num_i(num_mag), .den_i(den_mag),
    .tag_i({p3_inv_q, qneg}), .valid_o(dv_v), .quot_o(dv_quot), .tag_o(dv_tag)
  );

  // Stage 5: log10 ppm in Q16.
  logic signed [TW-1:0] q_ext, t_q;
  logic                 p5_v_q, p5_inv_q;

  // Stage 6: range flags and clamped value.
  logic [TC_W-1:0] tc_q;
  logic            p6_v_q, p6_inv_q, p6_neg_q, p6_big_q;

  // Stage 7: log2 ppm product.
  logic [PRW-1:0]  prod_q;
  logic            p7_v_q, p7_inv_q, p7_neg_q, p7_big_q;

  assign q_ext = $signed(TW'(dv_quot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
      p7_v_q <= 1'b0;
    end else if (adv) begin
      p5_v_q <= dv_v;
      p6_v_q <= p5_v_q;
      p7_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q      <= (dv_tag[0] ? -q_ext : q_ext) + TW'($signed({clp_q, 8'h00}));
      p5_inv_q <= dv_tag[1];
      tc_q     <= t_q[TC_W-1:0];
      p6_neg_q <= t_q[TW-1];
      p6_big_q <= !t_q[TW-1] && (|t_q[TW-2:TC_W]);
      p6_inv_q <= p5_inv_q;
      prod_q   <= PRW'(tc_q) * PRW'(LOG2_10_Q16);
      p7_neg_q <= p6_neg_q;
      p7_big_q <= p6_big_q;
      p7_inv_q <= p6_inv_q;
    end
  end

  // Split the log2 of ppm into integer and fraction for the 2^x unit.
  logic [EW-1:0] e_val;
  logic          e_sat;
  logic [4:0]    e_int;

  always_comb begin
    e_val = prod_q[PRW-1:Q_FRAC];
    e_sat = p7_big_q || (e_val >= E_SAT);
    e_int = e_val[Q_FRAC +: 5];
  end

  logic        ex_v;
  logic [30:0] ex_mant;
  logic [7:0]  ex_tag;

  gspl_exp2 #(.TAG_W(8)) u_exp (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(p7_v_q), .frac_i(e_val[Q_FRAC-1:0]),
    .tag_i({p7_inv_q, e_sat, p7_neg_q, e_int}),
    .valid_o(ex_v), .mant_o(ex_mant), .tag_o(ex_tag)
  );

  // Stage 9: scale the mantissa by 2^k and drop the Q30 fraction. One spare
  // bit keeps a 2^31 scale from wrapping before the saturation check.
  logic [32:0] sh_d, sh_q;
  logic        p9_v_q, p9_inv_q, p9_sat_q, p9_zero_q;

  always_comb begin
    if (ex_tag[4:0] <= 5'd30) begin
      sh_d = 33'(ex_mant) >> (5'd30 - ex_tag[4:0]);
    end else begin
      sh_d = 33'(ex_mant) << (ex_tag[4:0] - 5'd30);
    end
  end

  // Stage 10: saturate, raise the alarm and present the result.
  logic [PPM_BITS-1:0] ppm_d, ppm_q;
  logic                alarm_d, alarm_q, inv_q;

  always_comb begin
    if (p9_inv_q || p9_zero_q) begin
      ppm_d = '0;
    end else if (p9_sat_q || (sh_q > 33'(PPM_MAX))) begin
      ppm_d = PPM_MAX[PPM_BITS-1:0];
    end else begin
      ppm_d = sh_q[PPM_BITS-1:0];
    end
    alarm_d = !p9_inv_q && (CW'(ppm_d) > CW'(thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p9_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      p9_v_q      <= ex_v;
      out_valid_q <= p9_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sh_q      <= sh_d;
      p9_inv_q  <= ex_tag[7];
      p9_sat_q  <= ex_tag[6];
      p9_zero_q <= ex_tag[5];
      ppm_q     <= ppm_d;
      alarm_q   <= alarm_d;
      inv_q     <= p9_inv_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ppm_o            = ppm_q;
  assign over_alarm_o     = alarm_q;
  assign sample_invalid_o = inv_q;

  // A rejected sample never carries a concentration or an alarm.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_invalid_o |-> (ppm_o == '0) && !over_alarm_o)
    else $error("invalid sample produced a nonzero result");

  // The alarm only fires above the configured threshold.
  a_alarm_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_alarm_o |-> (CW'(ppm_o) > CW'(thr_q)))
    else $error("alarm raised at or below threshold");

  // A held result freezes the pipeline, so no new request can enter.
  a_hold_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while the output is held");

endmodule

FILE: hw/rtl/gspl_log2.sv
module gspl_log2 #(
  parameter int unsigned XW    = 28,
  parameter int unsigned TAG_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [XW-1:0]            x_i,
  input  logic [TAG_W-1:0]         tag_i,
  output logic                     valid_o,
  output logic [$clog2(XW)-1:0]    top_o,
  output logic [gspl_pkg::Q_FRAC-1:0] frac_o,
  output logic [TAG_W-1:0]         tag_o
);
  import gspl_pkg::*;

  localparam int unsigned TOPW = $clog2(XW);

  logic [TOPW-1:0] lead;
  logic [31:0]     y_init;

  // Position of the top set bit, then the mantissa normalized to Q31.
  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) begin
        lead = TOPW'(i);
      end
    end
    y_init = 32'(x_i) << (5'd31 - 5'(lead));
  end

  logic [31:0]       y_q   [0:Q_FRAC];
  logic [Q_FRAC-1:0] fr_q  [0:Q_FRAC];
  logic [TOPW-1:0]   top_q [0:Q_FRAC];
  logic [TAG_W-1:0]  tag_q [0:Q_FRAC];
  logic              v_q   [0:Q_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q[0]   <= y_init;
      fr_q[0]  <= '0;
      top_q[0] <= lead;
      tag_q[0] <= tag_i;
    end
  end

  // Each stage squares the mantissa once and yields one fraction bit.
  for (genvar j = 1; j <= Q_FRAC; j++) begin : g_sq
    logic [63:0]       prod;
    logic [32:0]       sq;
    logic [31:0]       y_d;
    logic [Q_FRAC-1:0] fr_d;

    always_comb begin
      prod = 64'(y_q[j-1]) * 64'(y_q[j-1]);
      sq   = prod[63:31];
      fr_d = fr_q[j-1];
      if (sq[32]) begin
        y_d            = sq[32:1];
        fr_d[Q_FRAC-j] = 1'b1;
      end else begin
        y_d = sq[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[j]   <= y_d;
        fr_q[j]  <= fr_d;
        top_q[j] <= top_q[j-1];
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  assign valid_o = v_q[Q_FRAC];
  assign top_o   = top_q[Q_FRAC];
  assign frac_o  = fr_q[Q_FRAC];
  assign tag_o   = tag_q[Q_FRAC];

endmodule

FILE: hw/rtl/gspl_div.sv
module gspl_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 16,
  parameter int unsigned TAG_W = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [TAG_W-1:0] tag_o
);
  import gspl_pkg::*;

  logic [DEN_W-1:0] rem_q [0:NUM_W];
  logic [NUM_W-1:0] nq_q  [0:NUM_W];
  logic [DEN_W-1:0] den_q [0:NUM_W];
  logic [TAG_W-1:0] tag_q [0:NUM_W];
  logic             v_q   [0:NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      nq_q[0]  <= num_i;
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= NUM_W; j++) begin : g_bit
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_d;
    logic             qbit;

    always_comb begin
      trial = {rem_q[j-1], nq_q[j-1][NUM_W-1]};
      qbit  = (trial >= {1'b0, den_q[j-1]});
      if (qbit) begin
        rem_d = DEN_W'(trial - {1'b0, den_q[j-1]});
      end else begin
        rem_d = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        nq_q[j]  <= {nq_q[j-1][NUM_W-2:0], qbit};
        den_q[j] <= den_q[j-1];
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  assign valid_o = v_q[NUM_W];
  assign quot_o  = nq_q[NUM_W];
  assign tag_o   = tag_q[NUM_W];

endmodule

FILE: hw/rtl/gspl_exp2.sv
module gspl_exp2 #(
  parameter int unsigned TAG_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [gspl_pkg::Q_FRAC-1:0] frac_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [30:0]                 mant_o,
  output logic [TAG_W-1:0]            tag_o
);
  import gspl_pkg::*;

  // 2^(2^-j) in Q30 for j = 1 .. 16.
  localparam logic [30:0] EXP2_TBL [Q_FRAC] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280437,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196444, 31'd1074468888, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
  };

  logic [30:0]       m_q   [0:Q_FRAC];
  logic [Q_FRAC-1:0] f_q   [0:Q_FRAC];
  logic [TAG_W-1:0]  tag_q [0:Q_FRAC];
  logic              v_q   [0:Q_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= 31'h4000_0000;
      f_q[0]   <= frac_i;
      tag_q[0] <= tag_i;
    end
  end

  // Stage j multiplies in 2^(2^-j) when fraction bit (16-j) is set.
  for (genvar j = 1; j <= Q_FRAC; j++) begin : g_mul
    logic [61:0] prod;
    logic [30:0] m_d;

    always_comb begin
      prod = 62'(m_q[j-1]) * 62'(EXP2_TBL[j-1]);
      m_d  = f_q[j-1][Q_FRAC-j] ? prod[60:30] : m_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[j]   <= m_d;
        f_q[j]   <= f_q[j-1];
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  assign valid_o = v_q[Q_FRAC];
  assign mant_o  = m_q[Q_FRAC];
  assign tag_o   = tag_q[Q_FRAC];

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gspl_pkg::*;

  localparam int unsigned SB = 12;
  localparam int unsigned PB = 20;
  localparam int unsigned LATENCY = 77;
  localparam logic [PB-1:0] PPM_MAX = {PB{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SB-1:0] adc_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [PB-1:0] ppm_o;
  logic over_alarm_o;
  logic sample_invalid_o;

  gas_sensor_ppm_power_law_core #(.SAMPLE_BITS(SB), .PPM_BITS(PB)) dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [PB-1:0] ppm;
    logic          alarm;
    logic          invalid;
  } reading_t;

  // Predictor copy of the register file.
  logic [15:0] load_res, base_res;
  logic signed [15:0] log_ppm_pt, log_ratio_pt, slope_reg;
  logic [19:0] alarm_lvl;

  reading_t expected_readings[$];
  int errors = 0;
  bit stim_done = 1'b0;

  localparam longint unsigned EXP2_FRAC[16] = '{
    1518500250, 1276901417, 1170923762, 1121280437,
    1097253708, 1085434106, 1079572136, 1076653033,
    1075196444, 1074468888, 1074105294, 1073923544,
    1073832680, 1073787251, 1073764537, 1073753181};

  // Q16 log2 by repeated squaring of a Q31 mantissa.
  function automatic longint log2_fix(longint unsigned x);
    int top;
    longint unsigned y;
    longint frac;
    top = 63;
    frac = 0;
    while (top > 0 && x[top] == 1'b0) top--;
    if (top <= 31) y = x << (31 - top);
    else y = x >> (top - 31);
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac = frac | (longint'(1) << i);
      end
    end
    return longint'(top) * 65536 + frac;
  endfunction

  function automatic reading_t predict_reading(logic [SB-1:0] s);
    reading_t r;
    longint unsigned n, d, m, p;
    longint l2, lr, t, e, slp, num;
    int k;
    logic [15:0] f;
    r = '0;
    if (s == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    n = (longint'(1) << SB) - s;
    n = n * load_res;
    d = longint'(s) * base_res;
    if (n == 0) n = 1;
    if (d == 0) d = 1;
    l2 = log2_fix(n) - log2_fix(d);
    lr = (l2 * 19728) / 65536;
    slp = (slope_reg == 0) ? -1 : longint'(slope_reg);
    t = ((lr - longint'(log_ratio_pt) * 256) * 256) / slp + longint'(log_ppm_pt) * 256;
    num = t * 217707;
    if (num >= 0) e = num / 65536;
    else e = -((-num + 65535) / 65536);
    if (e < 0) p = 0;
    else if (e >= longint'(PB) * 65536) p = PPM_MAX;
    else begin
      k = int'(e >>> 16);
      f = e[15:0];
      m = 64'd1073741824;
      for (int i = 0; i < 16; i++)
        if (f[15-i]) m = (m * EXP2_FRAC[i]) >> 30;
      p = (m << k) >> 30;
      if (p > PPM_MAX) p = PPM_MAX;
    end
    r.ppm = p[PB-1:0];
    r.alarm = (p > alarm_lvl);
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_LOAD_RES:  load_res = val[15:0];
      CFG_BASE_RES:  base_res = val[15:0];
      CFG_CURVE_PPM: log_ppm_pt = val[15:0];
      CFG_CURVE_RAT: log_ratio_pt = val[15:0];
      CFG_CURVE_SLP: slope_reg = val[15:0];
      CFG_ALARM_THR: alarm_lvl = val[19:0];
      default: ;
    endcase
  endtask

  // Every request yields one result, so an empty queue means idle; the extra
  // cycles only cover the output register settling.
  task automatic wait_idle();
    while (expected_readings.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Sends one request after a random gap; a known result may be forced.
  task automatic send_request(logic [SB-1:0] s, bit fixed, reading_t fixed_res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    adc_sample_i = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_readings.push_back(fixed ? fixed_res : predict_reading(s));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver back-pressure: a fresh stall length per result.
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      out_stall_i = (hold != 0);
      repeat (hold) @(negedge clk_i);
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Scoreboard: compare each accepted result with the oldest request.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result with no request pending: ppm=%0d", $realtime, ppm_o);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (ppm_o !== want.ppm) begin
          $display("%0t: ppm expected %0d actual %0d", $realtime, want.ppm, ppm_o);
          errors++;
        end
        if (over_alarm_o !== want.alarm) begin
          $display("%0t: over_alarm expected %0b actual %0b", $realtime, want.alarm,
                   over_alarm_o);
          errors++;
        end
        if (sample_invalid_o !== want.invalid) begin
          $display("%0t: sample_invalid expected %0b actual %0b", $realtime,
                   want.invalid, sample_invalid_o);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [SB-1:0] sample;
    bit            fixed;
    reading_t      res;
  } vector_t;

  // Directed rows at reset settings: zero sample, full-scale edges, midscale.
  localparam int N_DIR = 12;
  vector_t dir_tab[N_DIR] = '{
    '{12'd0,    1'b1, '{20'd0, 1'b0, 1'b1}},
    '{12'd1,    1'b0, '0},
    '{12'd2,    1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd4094, 1'b0, '0},
    '{12'd2048, 1'b0, '0},
    '{12'd2730, 1'b0, '0},
    '{12'd1365, 1'b0, '0},
    '{12'd0,    1'b1, '{20'd0, 1'b0, 1'b1}},
    '{12'd3000, 1'b0, '0},
    '{12'd100,  1'b0, '0},
    '{12'hAAA,  1'b0, '0}};

  task automatic random_phase(int count);
    logic [SB-1:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: s = 12'd0;
        1: s = SB'($urandom_range(1, 8));
        2: s = 12'd4095 - SB'($urandom_range(0, 8));
        default: s = SB'($urandom);
      endcase
      send_request(s, 1'b0, '0);
    end
    wait_idle();
  endtask

  function automatic logic [15:0] rand_slope();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h0000;  // treated as -1
      3: return 16'($urandom_range(1, 300));  // positive slope
      default: return 16'(-$urandom_range(1, 2000));
    endcase
  endfunction

  initial begin
    reading_t zero_res;
    zero_res = '0;
    load_res = 16'd2560;
    base_res = 16'd2560;
    log_ppm_pt = 16'sd589;
    log_ratio_pt = 16'sd184;
    slope_reg = -16'sd87;
    alarm_lvl = 20'd200;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_tab[i].sample, dir_tab[i].fixed, dir_tab[i].res);
    wait_idle();

    // Extremes: zero resistances, huge threshold, steepest and flattest slope.
    write_reg(CFG_LOAD_RES, 20'd0);
    write_reg(CFG_ALARM_THR, 20'hFFFFF);
    send_request(12'd2048, 1'b0, '0);
    send_request(12'd1, 1'b0, '0);
    wait_idle();
    write_reg(CFG_LOAD_RES, 20'hFFFF);
    write_reg(CFG_BASE_RES, 20'd0);
    write_reg(CFG_ALARM_THR, 20'd0);
    write_reg(CFG_CURVE_SLP, 20'h0FFFF);
    write_reg(CFG_CURVE_PPM, 20'h07FFF);
    write_reg(CFG_CURVE_RAT, 20'h08000);
    send_request(12'd1, 1'b0, '0);
    send_request(12'd4095, 1'b0, '0);
    send_request(12'd0, 1'b1, '{20'd0, 1'b0, 1'b1});
    wait_idle();
    write_reg(CFG_CURVE_SLP, 20'h08000);
    write_reg(CFG_CURVE_PPM, 20'h08000);
    write_reg(CFG_CURVE_RAT, 20'h07FFF);
    write_reg(CFG_BASE_RES, 20'hFFFF);
    send_request(12'd4095, 1'b0, '0);
    send_request(12'd1, 1'b0, '0);
    wait_idle();

    // Reset-default curve first, then random register sets.
    write_reg(CFG_LOAD_RES, 20'd2560);
    write_reg(CFG_BASE_RES, 20'd2560);
    write_reg(CFG_CURVE_PPM, 20'd589);
    write_reg(CFG_CURVE_RAT, 20'd184);
    write_reg(CFG_CURVE_SLP, 20'hFFFA9);
    write_reg(CFG_ALARM_THR, 20'd200);
    random_phase(200);
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_LOAD_RES, CFG_DATA_W'($urandom));
      write_reg(CFG_BASE_RES, CFG_DATA_W'($urandom));
      write_reg(CFG_CURVE_PPM, CFG_DATA_W'(($urandom_range(0, 1) != 0) ? $urandom
                                                           : $urandom_range(0, 1200)));
      write_reg(CFG_CURVE_RAT, CFG_DATA_W'(($urandom_range(0, 1) != 0) ? $urandom
                                                           : $urandom_range(0, 600)));
      write_reg(CFG_CURVE_SLP, {4'($urandom_range(0, 15)), rand_slope()});
      write_reg(CFG_ALARM_THR, CFG_DATA_W'(($urandom_range(0, 1) != 0) ? $urandom
                                                           : $urandom_range(0, 2000)));
      random_phase(100);
    end

    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0 && expected_readings.size() == 0)
      $display("** gas_sensor_ppm_power_law_core: PASSED **");
    else
      $display("** gas_sensor_ppm_power_law_core: FAILED **");
    $finish;
  end

  // Watchdog: far beyond 1000 requests each with both worst-case gaps plus latency.
  initial begin
    #(10 * 400000);
    $display("** gas_sensor_ppm_power_law_core: FAILED **");
    $finish;
  end

endmodule
